@@ design/dps_pkg.sv @@
package dps_pkg;

    // Operation codes carried on the input tuser bit.
    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Event codes reported on the output tuser bits.
    localparam logic [1:0] EV_ADMIT   = 2'd0;
    localparam logic [1:0] EV_SUSPEND = 2'd1;
    localparam logic [1:0] EV_RAN     = 2'd2;
    localparam logic [1:0] EV_IDLE    = 2'd3;

    // Reset value of the admission limit register.
    localparam logic [3:0] SLOT_LIMIT_RESET = 4'd5;

    // Lowest priority that an entry can hold.
    localparam logic signed [9:0] PRIO_FLOOR = -10'sd256;

    // One ready-list entry as it is stored in the entry memory.
    typedef struct packed {
        logic [7:0]        tag;
        logic [7:0]        run_time;
        logic signed [9:0] prio;
    } entry_t;

    // One input transaction, unpacked.
    typedef struct packed {
        logic       op;
        logic [7:0] proc_tag;
        logic [7:0] run_time;
        logic [7:0] start_priority;
    } item_t;

    // One result, handed from the sequencer to the output register.
    typedef struct packed {
        logic [1:0]        event_res;
        logic [7:0]        out_tag;
        logic signed [8:0] time_left;
        logic signed [8:0] new_priority;
        logic              finished;
    } result_t;

endpackage

@@ design/dynamic_priority_scheduler.sv @@
// Channel  | Direction | Signals                        | Contents
// ---------+-----------+--------------------------------+---------------------------------
// s_*      | in        | s_tvalid s_tready s_tdata s_tuser | process admit or scheduling tick
// m_*      | out       | m_tvalid m_tready m_tdata m_tuser | one result per input transaction
// cfg_*    | in        | cfg_we cfg_wdata               | admission limit (slot_limit)
//
// An admit, or a tick on an empty list, goes straight to handing off its result. A tick
// on a non-empty list scans the entry memory for the highest priority, primes the read
// port, steps over each entry from the winner to the tail to compact the list and
// write the aged entry back, then hands off the result and takes the next transaction.
// Reset clears the sequencer, the list counters and the output valid flag and
// loads the admission limit with 5; the entry memory itself is not cleared.
// A stalled result waits in the output register while the next input
// transaction is already taken and worked on.
module dynamic_priority_scheduler
    import dps_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // proc_tag[7:0], run_time[15:8], start_priority[23:16]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_tag[7:0], time_left[16:8], new_priority[25:17],
                                   // finished[26], zero[31:27]
    output logic [1:0]  m_tuser,   // event_res
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata  // slot_limit
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [3:0]  slot_limit_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    item_t         item;
    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [IW-1:0] ram_raddr;
    entry_t        ram_rdata;

    // Unpack the input transaction.
    assign item = '{op: s_tuser, proc_tag: s_tdata[7:0], run_time: s_tdata[15:8],
                    start_priority: s_tdata[23:16]};

    // Admission limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg <= SLOT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            slot_limit_reg <= cfg_wdata;
        end
    end

    dps_sched #(
        .SLOTS (SLOTS)
    ) u_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .slot_limit (slot_limit_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    dps_entry_ram #(
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: takes a new result whenever it is empty or drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {5'b00000, res.finished, res.new_priority, res.time_left,
                            res.out_tag};
            m_tuser_reg <= res.event_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ design/dps_entry_ram.sv @@
module dps_entry_ram
    import dps_pkg::*;
#(
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // One write port and one registered read port; a read of the address
    // being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/dps_sched.sv @@
module dps_sched
    import dps_pkg::*;
#(
    parameter int SLOTS = 8,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  item_t         item,
    input  logic [3:0]    slot_limit,
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res,
    output logic          ram_we,
    output logic [IW-1:0] ram_waddr,
    output entry_t        ram_wdata,
    output logic [IW-1:0] ram_raddr,
    input  entry_t        ram_rdata
);

    localparam int CMPW = (CW > 4) ? CW : 4;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN     = 5'b00010,
        S_SHIFT_RD = 5'b00100,
        S_SHIFT    = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] ready_count_reg;
    logic [CW-1:0] admitted_count_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] best_idx_reg;
    entry_t        best_reg;
    result_t       res_reg;

    logic              accept;
    logic              admit_ok;
    logic [CW-1:0]     last_idx;
    logic [CW-1:0]     idx_ext;
    logic              scan_take;
    logic              at_last;
    logic              keep;
    logic signed [8:0] tl;
    logic signed [9:0] pr;

    // Handshake toward the input and the output register.
    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign res_valid  = (state_reg == S_DONE);
    assign res        = res_reg;

    // Admission check against the limit register and the list capacity.
    assign admit_ok = (CMPW'(admitted_count_reg) < CMPW'(slot_limit))
                   && (admitted_count_reg < SLOTS_C)
                   && (ready_count_reg < SLOTS_C);

    // Position tracking for the scan and the compaction passes.
    assign last_idx = ready_count_reg - CW'(1);
    assign idx_ext  = CW'(idx_reg);
    assign at_last  = (idx_ext == last_idx);

    // Strict compare keeps the earliest entry on a tie.
    assign scan_take = (idx_reg == '0) || (ram_rdata.prio > best_reg.prio);

    // Aging of the selected entry.
    assign tl   = $signed({1'b0, best_reg.run_time}) - 9'sd1;
    assign keep = (best_reg.run_time > 8'd1);
    assign pr   = (best_reg.prio == PRIO_FLOOR) ? PRIO_FLOOR : best_reg.prio - 10'sd1;

    // Memory port control. Reads run ahead of writes while the compaction pass
    // shifts entries, so each shifted entry is read before its slot is overwritten.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '{tag: item.proc_tag, run_time: item.run_time,
                      prio: $signed({2'b00, item.start_priority})};
        ram_raddr = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                if (accept && item.op == OP_ADMIT && admit_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IW'(ready_count_reg);
                end
            end
            S_SCAN:
            begin
                ram_raddr = idx_reg + IW'(1);
            end
            S_SHIFT_RD:
            begin
                ram_raddr = best_idx_reg + IW'(1);
            end
            S_SHIFT:
            begin
                if (!at_last)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    ram_raddr = idx_reg + IW'(2);
                end
                else if (keep)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{tag: best_reg.tag, run_time: tl[7:0], prio: pr};
                end
            end
            S_DONE:
            begin
                ram_raddr = idx_reg;
            end
            default:
            begin
                ram_raddr = idx_reg;
            end
        endcase
    end

    // Sequencer state and list counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            ready_count_reg    <= '0;
            admitted_count_reg <= '0;
            idx_reg            <= '0;
            best_idx_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.op == OP_ADMIT)
                        begin
                            if (admit_ok)
                            begin
                                ready_count_reg    <= ready_count_reg + CW'(1);
                                admitted_count_reg <= admitted_count_reg + CW'(1);
                            end
                            state_reg <= S_DONE;
                        end
                        else if (ready_count_reg == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_take)
                    begin
                        best_idx_reg <= idx_reg;
                    end
                    if (at_last)
                    begin
                        state_reg <= S_SHIFT_RD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_SHIFT_RD:
                begin
                    idx_reg   <= best_idx_reg;
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (!at_last)
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                    else
                    begin
                        if (!keep)
                        begin
                            ready_count_reg <= ready_count_reg - CW'(1);
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Best-entry and result payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && scan_take)
        begin
            best_reg <= ram_rdata;
        end
        if (state_reg == S_IDLE && accept)
        begin
            if (item.op == OP_ADMIT)
            begin
                res_reg <= '{event_res: admit_ok ? EV_ADMIT : EV_SUSPEND,
                             out_tag: item.proc_tag, time_left: '0,
                             new_priority: '0, finished: 1'b0};
            end
            else
            begin
                res_reg <= '{event_res: EV_IDLE, out_tag: '0, time_left: '0,
                             new_priority: '0, finished: 1'b0};
            end
        end
        else if (state_reg == S_SHIFT && at_last)
        begin
            res_reg <= '{event_res: EV_RAN, out_tag: best_reg.tag, time_left: tl,
                         new_priority: pr[8:0], finished: !keep};
        end
    end

    // The ready list never holds more entries than were ever admitted.
    a_ready_le_admitted: assert property (@(posedge clk) disable iff (!rst_n)
        ready_count_reg <= admitted_count_reg)
        else $error("ready list larger than admission count");

    // The admission count stays within the list capacity.
    a_admitted_cap: assert property (@(posedge clk) disable iff (!rst_n)
        admitted_count_reg <= SLOTS_C)
        else $error("admission count above capacity");

    // The admission count is never released.
    a_admitted_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> admitted_count_reg >= $past(admitted_count_reg))
        else $error("admission count decreased");

    // A finished process leaves the list by exactly one entry.
    a_drop_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && at_last && !keep)
        |=> ready_count_reg == $past(ready_count_reg) - CW'(1))
        else $error("finished process not dropped from the list");

endmodule
